// File: design/persistent_array_versions_defines.svh
// ----------------------------------------------------------------------------
// persistent_array_versions_defines.svh
// assertion macros used by the persistent array design file
// ----------------------------------------------------------------------------
`ifndef PERSISTENT_ARRAY_VERSIONS_DEFINES_SVH
`define PERSISTENT_ARRAY_VERSIONS_DEFINES_SVH

// same-cycle implication, disabled in reset
`define PAV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define PAV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/pav_pkg.sv
// ----------------------------------------------------------------------------
// pav_pkg
// constants, types and codes of the persistent array block
// ----------------------------------------------------------------------------
package pav_pkg;

  localparam int MAX_LEN     = 1024;
  localparam int NODE_CAP    = 16384;
  localparam int VERSION_CAP = 1024;
  localparam int DATA_WIDTH  = 32;

  localparam int LEN_W   = 11;
  localparam int POS_W   = 10;
  localparam int VER_W   = 10;
  localparam int VCNT_W  = 11;
  localparam int NODE_AW = 14;
  localparam int NCNT_W  = 15;
  localparam int NEED_W  = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_ARRAY_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_VALUE   = 2'd1;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_VER  = 2'd1;
  localparam logic [1:0] ST_BAD_POS  = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // imp set: node of the untouched initial tree, value is the fill value
  typedef struct packed {
    logic               imp;
    logic [NODE_AW-1:0] idx;
  } ptr_t;

  typedef struct packed {
    ptr_t                  left;
    ptr_t                  right;
    logic [DATA_WIDTH-1:0] val;
  } node_t;

  localparam ptr_t IMP_PTR = '{imp: 1'b1, idx: '0};

endpackage

// File: design/pav_req_if.sv
// ----------------------------------------------------------------------------
// pav_req_if
// request channel: read or write of one position of one version
// ----------------------------------------------------------------------------
interface pav_req_if;
  logic                              valid;
  logic                              ready;
  logic                              opcode;
  logic [pav_pkg::VER_W-1:0]         version;
  logic [pav_pkg::POS_W-1:0]         position;
  logic [pav_pkg::DATA_WIDTH-1:0]    value;

  modport source(output valid, opcode, version, position, value, input ready);
  modport sink(input valid, opcode, version, position, value, output ready);
endinterface

// File: design/pav_rsp_if.sv
// ----------------------------------------------------------------------------
// pav_rsp_if
// response channel: value read, version made and status
// ----------------------------------------------------------------------------
interface pav_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [pav_pkg::DATA_WIDTH-1:0]    read_value;
  logic [pav_pkg::VER_W-1:0]         new_version;
  logic [1:0]                        status;

  modport source(output valid, read_value, new_version, status, input ready);
  modport sink(input valid, read_value, new_version, status, output ready);
endinterface

// File: design/persistent_array_versions.sv
// ----------------------------------------------------------------------------
// persistent_array_versions
// fully persistent array, implicit balanced tree with path copying
//
// req carries one item: opcode (read or write), version, position, value.
// rsp returns one item per request: read_value, new_version, status.
// cfg_we/cfg_index/cfg_data write array_length (0) or fill_value (1); either
// write drops every version and leaves version 0 at the fill value at once.
// A request is taken only when the sequencer is idle. One shared step unit
// halves the subtree size per tree level and the node memory is read once
// per level with a registered read. A read walks down to the position, one
// node per level (at most 11 levels for 1024 positions); a write runs a
// count pass, then a copy pass; a bad version or bad position goes straight
// to the response.
// Nodes of version 0 are never stored, so reset and configuration need no
// clearing pass. Reset empties the array (length 0) with version 0 only.
// A finished item waits in the rsp register while a new request is taken;
// when rsp stalls, the next item is held until that register is free.
// ----------------------------------------------------------------------------
`include "persistent_array_versions_defines.svh"

module persistent_array_versions (
  input  logic                                clk,
  input  logic                                rst,
  pav_req_if.sink                             req,
  pav_rsp_if.source                           rsp,
  input  logic                                cfg_we,
  input  logic [pav_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pav_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_ROOT     = 4'd1;
  localparam logic [3:0] S_RD_ISSUE = 4'd2;
  localparam logic [3:0] S_RD_DATA  = 4'd3;
  localparam logic [3:0] S_COUNT    = 4'd4;
  localparam logic [3:0] S_CHECK    = 4'd5;
  localparam logic [3:0] S_CP_ISSUE = 4'd6;
  localparam logic [3:0] S_CP_DATA  = 4'd7;
  localparam logic [3:0] S_DONE     = 4'd8;

  logic [3:0]                          state;
  logic [pav_pkg::LEN_W-1:0]           eff_len;
  logic [pav_pkg::DATA_WIDTH-1:0]      fill;
  logic [pav_pkg::VCNT_W-1:0]          versions_made;
  logic [pav_pkg::NCNT_W-1:0]          nodes_used;
  logic [pav_pkg::NCNT_W-1:0]          alloc;
  logic [pav_pkg::NEED_W-1:0]          need;

  logic                                op;
  logic [pav_pkg::VER_W-1:0]           ver;
  logic [pav_pkg::DATA_WIDTH-1:0]      wval;

  logic [pav_pkg::LEN_W-1:0]           sz;
  logic [pav_pkg::POS_W-1:0]           p;
  logic [pav_pkg::POS_W-1:0]           pos0;
  pav_pkg::ptr_t                       cur;

  logic [pav_pkg::DATA_WIDTH-1:0]      res_val;
  logic [pav_pkg::VER_W-1:0]           res_ver;
  logic [1:0]                          res_status;

  logic                                out_valid;
  logic [pav_pkg::DATA_WIDTH-1:0]      out_val;
  logic [pav_pkg::VER_W-1:0]           out_ver;
  logic [1:0]                          out_status;

  pav_pkg::node_t                      node_mem [pav_pkg::NODE_CAP];
  pav_pkg::node_t                      node_q;
  pav_pkg::node_t                      src;
  pav_pkg::node_t                      node_wdata;
  logic                                node_we;

  pav_pkg::ptr_t                       roots_mem [pav_pkg::VERSION_CAP];
  pav_pkg::ptr_t                       root_q;
  logic                                root_we;

  // shared step unit
  logic [pav_pkg::POS_W-1:0]           szl;
  logic                                hit;
  logic                                go_left;
  logic [pav_pkg::LEN_W-1:0]           sz_nx;
  logic [pav_pkg::POS_W-1:0]           p_nx;

  logic                                req_fire;
  logic                                load_out;
  logic                                full;
  logic [pav_pkg::LEN_W-1:0]           cfg_len;
  logic [pav_pkg::NCNT_W-1:0]          alloc_nx;
  pav_pkg::ptr_t                       child;

  assign req.ready   = (state == S_IDLE);
  assign req_fire    = req.valid && req.ready;
  assign load_out    = (state == S_DONE) && (!out_valid || rsp.ready);

  assign rsp.valid       = out_valid;
  assign rsp.read_value  = out_val;
  assign rsp.new_version = out_ver;
  assign rsp.status      = out_status;

  always_comb begin
    szl     = sz[pav_pkg::LEN_W-1:1];
    hit     = (p == szl);
    go_left = (p < szl);
    sz_nx   = go_left ? {1'b0, szl} : sz - {1'b0, szl} - pav_pkg::LEN_W'(1);
    p_nx    = go_left ? p : p - szl - pav_pkg::POS_W'(1);
  end

  assign cfg_len = (cfg_data[pav_pkg::LEN_W-1:0] > pav_pkg::LEN_W'(pav_pkg::MAX_LEN)) ?
                   pav_pkg::LEN_W'(pav_pkg::MAX_LEN) : cfg_data[pav_pkg::LEN_W-1:0];

  assign full = (versions_made >= pav_pkg::VCNT_W'(pav_pkg::VERSION_CAP)) ||
                (({1'b0, nodes_used} + (pav_pkg::NCNT_W + 1)'(need)) >
                 (pav_pkg::NCNT_W + 1)'(pav_pkg::NODE_CAP));

  assign alloc_nx = alloc + pav_pkg::NCNT_W'(1);

  always_comb begin
    if (cur.imp) begin
      src = '{left: pav_pkg::IMP_PTR, right: pav_pkg::IMP_PTR, val: fill};
    end else begin
      src = node_q;
    end
    child = go_left ? src.left : src.right;
    node_we = (state == S_CP_DATA);
    node_wdata = src;
    if (hit) begin
      node_wdata.val = wval;
    end else if (go_left) begin
      node_wdata.left = '{imp: 1'b0, idx: alloc_nx[pav_pkg::NODE_AW-1:0]};
    end else begin
      node_wdata.right = '{imp: 1'b0, idx: alloc_nx[pav_pkg::NODE_AW-1:0]};
    end
    root_we = (state == S_CHECK) && !full;
  end

  // node memory
  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[alloc[pav_pkg::NODE_AW-1:0]] <= node_wdata;
    end
    node_q <= node_mem[cur.idx];
  end

  // version root memory
  always_ff @(posedge clk) begin
    if (root_we) begin
      roots_mem[versions_made[pav_pkg::VER_W-1:0]] <=
        '{imp: 1'b0, idx: nodes_used[pav_pkg::NODE_AW-1:0]};
    end
    if (req_fire) begin
      root_q <= roots_mem[req.version];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      eff_len       <= '0;
      fill          <= '0;
      versions_made <= pav_pkg::VCNT_W'(1);
      nodes_used    <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      if (cfg_we && cfg_index == pav_pkg::CFG_ARRAY_LENGTH) begin
        eff_len       <= cfg_len;
        versions_made <= pav_pkg::VCNT_W'(1);
        nodes_used    <= pav_pkg::NCNT_W'(cfg_len);
      end else if (cfg_we && cfg_index == pav_pkg::CFG_FILL_VALUE) begin
        fill          <= cfg_data[pav_pkg::DATA_WIDTH-1:0];
        versions_made <= pav_pkg::VCNT_W'(1);
        nodes_used    <= pav_pkg::NCNT_W'(eff_len);
      end

      case (state)
        S_IDLE: begin
          if (req_fire) begin
            op         <= req.opcode;
            ver        <= req.version;
            wval       <= req.value;
            pos0       <= req.position;
            sz         <= eff_len;
            p          <= req.position;
            need       <= pav_pkg::NEED_W'(1);
            res_val    <= '0;
            res_ver    <= '0;
            if ({1'b0, req.version} >= versions_made) begin
              res_status <= pav_pkg::ST_BAD_VER;
              state      <= S_DONE;
            end else if ({1'b0, req.position} >= eff_len) begin
              res_status <= pav_pkg::ST_BAD_POS;
              state      <= S_DONE;
            end else if (req.opcode == pav_pkg::OP_WRITE) begin
              res_status <= pav_pkg::ST_OK;
              state      <= S_COUNT;
            end else begin
              res_status <= pav_pkg::ST_OK;
              state      <= S_ROOT;
            end
          end
        end
        S_ROOT: begin
          cur   <= (ver == '0) ? pav_pkg::IMP_PTR : root_q;
          state <= S_RD_ISSUE;
        end
        S_RD_ISSUE: begin
          state <= S_RD_DATA;
        end
        S_RD_DATA: begin
          if (hit) begin
            res_val <= src.val;
            state   <= S_DONE;
          end else begin
            cur   <= child;
            sz    <= sz_nx;
            p     <= p_nx;
            state <= S_RD_ISSUE;
          end
        end
        S_COUNT: begin
          if (hit) begin
            state <= S_CHECK;
          end else begin
            need <= need + pav_pkg::NEED_W'(1);
            sz   <= sz_nx;
            p    <= p_nx;
          end
        end
        S_CHECK: begin
          if (full) begin
            res_status <= pav_pkg::ST_FULL;
            state      <= S_DONE;
          end else begin
            cur   <= (ver == '0) ? pav_pkg::IMP_PTR : root_q;
            sz    <= eff_len;
            p     <= pos0;
            alloc <= nodes_used;
            state <= S_CP_ISSUE;
          end
        end
        S_CP_ISSUE: begin
          state <= S_CP_DATA;
        end
        S_CP_DATA: begin
          alloc <= alloc_nx;
          if (hit) begin
            res_ver       <= versions_made[pav_pkg::VER_W-1:0];
            versions_made <= versions_made + pav_pkg::VCNT_W'(1);
            nodes_used    <= alloc_nx;
            state         <= S_DONE;
          end else begin
            cur   <= child;
            sz    <= sz_nx;
            p     <= p_nx;
            state <= S_CP_ISSUE;
          end
        end
        S_DONE: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_val    <= res_val;
      out_ver    <= res_ver;
      out_status <= res_status;
    end
  end

  `PAV_ASSERT_NOW(a_alloc_in_range, state == S_CP_DATA,
    alloc < pav_pkg::NCNT_W'(pav_pkg::NODE_CAP), "node allocation beyond capacity")
  `PAV_ASSERT_NEXT(a_version_step, state == S_CP_DATA && hit && !cfg_we,
    versions_made == $past(versions_made) + pav_pkg::VCNT_W'(1),
    "version count did not advance by one")
  `PAV_ASSERT_NOW(a_write_version, state == S_CP_DATA && hit,
    versions_made != '0 && versions_made < pav_pkg::VCNT_W'(pav_pkg::VERSION_CAP),
    "new version outside table")
  `PAV_ASSERT_NOW(a_full_on_write, state == S_DONE && res_status == pav_pkg::ST_FULL,
    op == pav_pkg::OP_WRITE && res_ver == '0, "full status on a read")

endmodule
